// File: rtl/cda_pkg.sv
// shared types, constants and calendar tables for the calendar date arithmetic block
package cda_pkg;

	// default number of valid years, 0 .. YEAR_SPAN_DEF-1
	localparam int YEAR_SPAN_DEF = 100;
	// entries in the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic CMD_DIFF = 1'b0;
	localparam logic CMD_ADD  = 1'b1;

	localparam logic [10:0] DAYS_QUAD = 11'd1461;
	localparam logic [8:0]  DAYS_YEAR = 9'd365;
	localparam logic [8:0]  DAYS_LEAP = 9'd366;

	// floor(2^RECIP_SHIFT / 1461), quotient is exact or one low
	localparam int          RECIP_SHIFT = 28;
	localparam logic [17:0] RECIP_QUAD  = 18'd183734;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_ORDER    = 2'd1,
		STATUS_OVERFLOW = 2'd2,
		STATUS_INVALID  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_FIX,
		BK_YEAR,
		BK_MONTH
	} back_state_t;

	typedef struct packed {
		logic        command;
		logic [4:0]  day_a;
		logic [3:0]  month_a;
		logic [6:0]  year_a;
		logic [4:0]  day_b;
		logic [3:0]  month_b;
		logic [6:0]  year_b;
		logic [15:0] add_days;
	} req_t;

	typedef struct packed {
		logic [4:0]  result_day;
		logic [3:0]  result_month;
		logic [6:0]  result_year;
		logic [15:0] day_count;
		status_t     status;
	} rsp_t;

	// classified item passed from front to back
	typedef struct packed {
		logic        decode;
		status_t     status;
		logic [15:0] day_count;
		logic [16:0] ordinal;
	} job_t;

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// days in the year before the first of month m
	function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
		logic [8:0] base;
		case (m)
			4'd1:    base = 9'd0;
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		if (leap && (m > 4'd2) && (m <= 4'd12)) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

// File: rtl/cda_front.sv
// front part: validates dates, computes day ordinals and classifies each item
module cda_front #(
	parameter int YEAR_SPAN = cda_pkg::YEAR_SPAN_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  cda_pkg::req_t   req,
	output logic            job_valid,
	input  logic            job_full,
	output cda_pkg::job_t   job
);

	localparam int TOTAL_DAYS = 365 * YEAR_SPAN + (YEAR_SPAN + 3) / 4;

	function automatic logic date_ok(input logic [4:0] d, input logic [3:0] m,
			input logic [6:0] y);
		logic       leap;
		logic [4:0] dim;
		leap = (y[1:0] == 2'b00);
		dim  = cda_pkg::month_days(m, leap);
		return (32'(y) < 32'(YEAR_SPAN)) && (m >= 4'd1) && (m <= 4'd12) &&
			(d >= 5'd1) && (d <= dim);
	endfunction

	// day number from 1 january of year 0
	function automatic logic [15:0] ordinal(input logic [4:0] d, input logic [3:0] m,
			input logic [6:0] y);
		logic       leap;
		logic [7:0] y_up;
		leap = (y[1:0] == 2'b00);
		y_up = 8'(y) + 8'd3;
		return 16'(y) * 16'd365 + 16'(y_up >> 2) + 16'(cda_pkg::days_before(m, leap)) +
			16'(d) - 16'd1;
	endfunction

	logic          ok_a;
	logic          ok_b;
	logic [15:0]   ord_a;
	logic [15:0]   ord_b;
	logic [16:0]   ord_sum;
	cda_pkg::job_t job_d;
	cda_pkg::job_t job_s1;
	logic          valid_s1;

	always_comb begin
		ok_a    = date_ok(req.day_a, req.month_a, req.year_a);
		ok_b    = date_ok(req.day_b, req.month_b, req.year_b);
		ord_a   = ordinal(req.day_a, req.month_a, req.year_a);
		ord_b   = ordinal(req.day_b, req.month_b, req.year_b);
		ord_sum = 17'(ord_a) + 17'(req.add_days);

		job_d.decode    = 1'b0;
		job_d.status    = cda_pkg::STATUS_OK;
		job_d.day_count = 16'd0;
		job_d.ordinal   = ord_sum;
		if (req.command == cda_pkg::CMD_DIFF) begin
			if (!ok_a || !ok_b) begin
				job_d.status = cda_pkg::STATUS_INVALID;
			end else if (ord_a < ord_b) begin
				job_d.status = cda_pkg::STATUS_ORDER;
			end else begin
				job_d.day_count = ord_a - ord_b;
			end
		end else begin
			if (!ok_a) begin
				job_d.status = cda_pkg::STATUS_INVALID;
			end else if (32'(ord_sum) >= 32'(TOTAL_DAYS)) begin
				job_d.status = cda_pkg::STATUS_OVERFLOW;
			end else begin
				job_d.decode = 1'b1;
			end
		end
	end

	assign req_stall = valid_s1 && job_full;
	assign job_valid = valid_s1;
	assign job       = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall) begin
			job_s1 <= job_d;
		end
	end

endmodule

// File: rtl/cda_queue.sv
// short register queue between front and back
module cda_queue #(
	parameter int DEPTH = cda_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cda_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output cda_pkg::job_t pop_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cda_pkg::job_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == CW'(0));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// File: rtl/cda_back.sv
// back part: turns a day ordinal into a date and drives the result register
module cda_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_empty,
	input  cda_pkg::job_t job,
	output logic          job_pop,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output cda_pkg::rsp_t rsp
);

	cda_pkg::back_state_t state_q;
	cda_pkg::back_state_t state_d;

	logic [16:0]   ord_q;
	logic [34:0]   prod_q;
	logic [6:0]    quad_q;
	logic [10:0]   rem_q;
	logic [6:0]    year_q;
	logic [8:0]    doy_q;
	logic          leap_q;
	logic          rsp_valid_q;
	cda_pkg::rsp_t rsp_q;

	logic          out_free;
	logic          ld_ord;
	logic          ld_direct;
	logic          ld_date;

	logic [6:0]    quad0;
	logic [16:0]   rem_wide;
	logic [11:0]   rem0;
	logic [6:0]    quad_fix;
	logic [10:0]   rem_fix;
	logic [10:0]   rem_late;
	logic [1:0]    year_in_run;
	logic [8:0]    year_full;
	logic [8:0]    doy_next;
	logic [3:0]    month;
	logic [8:0]    day_off;

	assign out_free = !rsp_valid_q || !rsp_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cda_pkg::BK_IDLE: begin
				if (!job_empty && job.decode) begin
					state_d = cda_pkg::BK_MUL;
				end
			end
			cda_pkg::BK_MUL:   state_d = cda_pkg::BK_FIX;
			cda_pkg::BK_FIX:   state_d = cda_pkg::BK_YEAR;
			cda_pkg::BK_YEAR:  state_d = cda_pkg::BK_MONTH;
			cda_pkg::BK_MONTH: begin
				if (out_free) begin
					state_d = cda_pkg::BK_IDLE;
				end
			end
			default: state_d = cda_pkg::BK_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ld_ord    = 1'b0;
		ld_direct = 1'b0;
		ld_date   = 1'b0;
		case (state_q)
			cda_pkg::BK_IDLE: begin
				ld_ord    = !job_empty && job.decode;
				ld_direct = !job_empty && !job.decode && out_free;
			end
			cda_pkg::BK_MONTH: ld_date = out_free;
			default: begin
				ld_ord    = 1'b0;
				ld_direct = 1'b0;
				ld_date   = 1'b0;
			end
		endcase
	end

	assign job_pop = ld_ord || ld_direct;

	// quotient by 1461 may be one low, one correction step
	always_comb begin
		quad0    = prod_q[cda_pkg::RECIP_SHIFT +: 7];
		rem_wide = ord_q - 17'(quad0) * 17'(cda_pkg::DAYS_QUAD);
		rem0     = rem_wide[11:0];
		if (rem0 >= 12'(cda_pkg::DAYS_QUAD)) begin
			quad_fix = quad0 + 7'd1;
			rem_fix  = 11'(rem0 - 12'(cda_pkg::DAYS_QUAD));
		end else begin
			quad_fix = quad0;
			rem_fix  = rem0[10:0];
		end
	end

	// year inside the four-year run
	always_comb begin
		rem_late    = rem_q - 11'(cda_pkg::DAYS_LEAP);
		year_in_run = 2'd0;
		doy_next    = rem_q[8:0];
		if (rem_q < 11'(cda_pkg::DAYS_LEAP)) begin
			year_full = {quad_q, 2'b00};
		end else begin
			if (rem_late < 11'd365) begin
				year_in_run = 2'd1;
				doy_next    = rem_late[8:0];
			end else if (rem_late < 11'd730) begin
				year_in_run = 2'd2;
				doy_next    = 9'(rem_late - 11'd365);
			end else begin
				year_in_run = 2'd3;
				doy_next    = 9'(rem_late - 11'd730);
			end
			year_full = {quad_q, 2'b00} + 9'(year_in_run);
		end
	end

	// month by compare against each month start
	always_comb begin
		month = 4'd1;
		for (int k = 2; k <= 12; k++) begin
			if (doy_q >= cda_pkg::days_before(4'(k), leap_q)) begin
				month = month + 4'd1;
			end
		end
		day_off = doy_q - cda_pkg::days_before(month, leap_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cda_pkg::BK_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_direct || ld_date) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_ord) begin
			ord_q <= job.ordinal;
		end
		if (state_q == cda_pkg::BK_MUL) begin
			prod_q <= 35'(ord_q) * 35'(cda_pkg::RECIP_QUAD);
		end
		if (state_q == cda_pkg::BK_FIX) begin
			quad_q <= quad_fix;
			rem_q  <= rem_fix;
		end
		if (state_q == cda_pkg::BK_YEAR) begin
			year_q <= year_full[6:0];
			doy_q  <= doy_next;
			leap_q <= (rem_q < 11'(cda_pkg::DAYS_LEAP));
		end
		if (ld_direct) begin
			rsp_q.result_day   <= 5'd1;
			rsp_q.result_month <= 4'd1;
			rsp_q.result_year  <= 7'd0;
			rsp_q.day_count    <= job.day_count;
			rsp_q.status       <= job.status;
		end else if (ld_date) begin
			rsp_q.result_day   <= 5'(day_off) + 5'd1;
			rsp_q.result_month <= month;
			rsp_q.result_year  <= year_q;
			rsp_q.day_count    <= 16'd0;
			rsp_q.status       <= cda_pkg::STATUS_OK;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_mul_to_fix: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cda_pkg::BK_MUL |=> state_q == cda_pkg::BK_FIX)
		else $error("multiply step not followed by correction step");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cda_pkg::BK_FIX |=> rem_q < 11'(cda_pkg::DAYS_QUAD))
		else $error("remainder by 1461 out of range after correction");

	a_doy_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cda_pkg::BK_MONTH |-> doy_q < 9'(cda_pkg::DAYS_LEAP))
		else $error("day of year out of range");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> state_q == cda_pkg::BK_IDLE && !job_empty)
		else $error("queue popped while busy or empty");
`endif

endmodule

// File: rtl/calendar_date_arithmetic.sv
// top level of the calendar date arithmetic block
//
// usage: each item on the req channel carries a command and two dd/mm/yy dates
// plus a day count; the rsp channel returns exactly one item per request, in order
// command 0 gives the day count from the second date to the first, command 1 adds
// add_days to the first date and returns the new date; status flags invalid dates,
// a first date earlier than the second and a result past the last year
// both channels accept an item at a clock edge with valid high and stall low
// path: difference and error items pass the front stage register, the queue and the
// result register; add items pass the back sequencer states as well
// throughput: difference and error items go through one per cycle unless the
// receiver stalls; add items go through the back sequencer steps (reciprocal
// multiply by 1/1461, remainder correction, year split, month search) one at a time
// a front stage validates and computes day ordinals, a short queue decouples it
// from the back sequencer, so the front keeps accepting while the back is busy
// when the receiver stalls the result register holds its item, the back waits, the
// queue fills and then req_stall rises
// reset (arst_n low) empties the front stage, the queue and the result register
module calendar_date_arithmetic #(
	parameter int YEAR_SPAN   = cda_pkg::YEAR_SPAN_DEF,
	parameter int QUEUE_DEPTH = cda_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  cda_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output cda_pkg::rsp_t rsp
);

	// classified item leaving the front stage
	logic          front_valid;
	cda_pkg::job_t front_job;

	// queue status and head item
	logic          queue_full;
	logic          queue_empty;
	logic          queue_pop;
	cda_pkg::job_t queue_job;

	cda_front #(
		.YEAR_SPAN (YEAR_SPAN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.job_valid (front_valid),
		.job_full  (queue_full),
		.job       (front_job)
	);

	cda_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (front_valid),
		.push_job (front_job),
		.full     (queue_full),
		.pop      (queue_pop),
		.empty    (queue_empty),
		.pop_job  (queue_job)
	);

	cda_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (queue_empty),
		.job       (queue_job),
		.job_pop   (queue_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench for the calendar date arithmetic block
module tb_top;

	// calendar span the block is built for, and the day count of that span
	localparam int unsigned YEAR_SPAN    = cda_pkg::YEAR_SPAN_DEF;
	localparam int unsigned SPAN_DAYS    = 365 * YEAR_SPAN + (YEAR_SPAN + 3) / 4;
	localparam int unsigned QUAD_DAYS    = cda_pkg::DAYS_QUAD;
	localparam int unsigned LEAP_DAYS    = cda_pkg::DAYS_LEAP;
	localparam int unsigned COMMON_DAYS  = cda_pkg::DAYS_YEAR;
	localparam int unsigned MAX_COUNT    = 65535;
	// cycles without any accepted item before the run is declared hung
	localparam int unsigned QUIET_LIMIT  = 1000;
	// settle time after the last result, well above the add latency
	localparam int unsigned TAIL_CYCLES  = 20;
	localparam int unsigned RESET_CYCLES = 7;

	typedef struct packed {
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
	} cal_date_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	cda_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	cda_pkg::rsp_t rsp;

	// results predicted for accepted items, oldest first
	cda_pkg::rsp_t expected_dates[$];
	int unsigned   mismatch_count   = 0;
	int unsigned   quiet_cycles     = 0;
	// idle controls shared by the sender, the receiver and the tests
	bit            sender_gaps_on   = 1'b0;
	bit            receiver_gaps_on = 1'b0;
	int unsigned   hold_off_cycles  = 0;

	calendar_date_arithmetic uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------
	// calendar predictor
	// ---------------------------------------------------------------

	// february is long in every year divisible by four, year 0 included
	function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
		int unsigned len;
		case (m)
			1, 3, 5, 7, 8, 10, 12: len = 31;
			4, 6, 9, 11:           len = 30;
			2:                     len = (y % 4 == 0) ? 29 : 28;
			default:               len = 0;
		endcase
		return len;
	endfunction

	function automatic bit date_valid(input int unsigned d, input int unsigned m,
			input int unsigned y);
		if (y >= YEAR_SPAN || m < 1 || m > 12) begin
			return 1'b0;
		end
		return d >= 1 && d <= month_length(m, y);
	endfunction

	// day 0 is 1 january of year 0
	function automatic int unsigned day_ordinal(input int unsigned d, input int unsigned m,
			input int unsigned y);
		int unsigned n;
		n = 365 * y + (y + 3) / 4;
		for (int unsigned k = 1; k < m; k++) begin
			n += month_length(k, y);
		end
		return n + d - 1;
	endfunction

	function automatic cda_pkg::rsp_t calc_date_result(input cda_pkg::req_t r);
		cda_pkg::rsp_t res;
		int unsigned   oa, ob, o, rem, y, m;
		// error results and the unused half of each command keep these values
		res.result_day   = 5'd1;
		res.result_month = 4'd1;
		res.result_year  = 7'd0;
		res.day_count    = 16'd0;
		res.status       = cda_pkg::STATUS_OK;
		if (r.command == cda_pkg::CMD_DIFF) begin
			// both dates must be valid for the difference
			if (!date_valid(r.day_a, r.month_a, r.year_a)
					|| !date_valid(r.day_b, r.month_b, r.year_b)) begin
				res.status = cda_pkg::STATUS_INVALID;
			end else begin
				oa = day_ordinal(r.day_a, r.month_a, r.year_a);
				ob = day_ordinal(r.day_b, r.month_b, r.year_b);
				if (oa < ob) begin
					res.status = cda_pkg::STATUS_ORDER;
				end else if (oa - ob > MAX_COUNT) begin
					res.status = cda_pkg::STATUS_OVERFLOW;
				end else begin
					res.day_count = 16'(oa - ob);
				end
			end
		end else begin
			// add ignores the second date entirely
			if (!date_valid(r.day_a, r.month_a, r.year_a)) begin
				res.status = cda_pkg::STATUS_INVALID;
			end else begin
				o = day_ordinal(r.day_a, r.month_a, r.year_a) + r.add_days;
				if (o >= SPAN_DAYS) begin
					res.status = cda_pkg::STATUS_OVERFLOW;
				end else begin
					// four-year blocks start with the leap year
					rem = o % QUAD_DAYS;
					y   = 4 * (o / QUAD_DAYS);
					if (rem >= LEAP_DAYS) begin
						rem = rem - LEAP_DAYS;
						y   = y + 1 + rem / COMMON_DAYS;
						rem = rem % COMMON_DAYS;
					end
					m = 1;
					while (m < 12 && rem >= month_length(m, y)) begin
						rem = rem - month_length(m, y);
						m++;
					end
					res.result_day   = 5'(rem + 1);
					res.result_month = 4'(m);
					res.result_year  = 7'(y);
				end
			end
		end
		return res;
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// mostly back to back, some short gaps and a few long ones
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end else if (roll < 97) begin
			return $urandom_range(4, 8);
		end
		return $urandom_range(10, 30);
	endfunction

	function automatic cda_pkg::req_t make_req(input logic cmd, input int unsigned da,
			input int unsigned ma, input int unsigned ya, input int unsigned db,
			input int unsigned mb, input int unsigned yb, input int unsigned n);
		cda_pkg::req_t r;
		r.command  = cmd;
		r.day_a    = 5'(da);
		r.month_a  = 4'(ma);
		r.year_a   = 7'(ya);
		r.day_b    = 5'(db);
		r.month_b  = 4'(mb);
		r.year_b   = 7'(yb);
		r.add_days = 16'(n);
		return r;
	endfunction

	// a valid date, with month ends and month starts favored
	function automatic cal_date_t random_date();
		cal_date_t   dt;
		int unsigned y, m, len, roll;
		y    = $urandom_range(0, YEAR_SPAN - 1);
		m    = $urandom_range(1, 12);
		len  = month_length(m, y);
		roll = $urandom_range(0, 9);
		dt.year  = 7'(y);
		dt.month = 4'(m);
		if (roll == 0) begin
			dt.day = 5'd1;
		end else if (roll == 1) begin
			dt.day = 5'(len);
		end else begin
			dt.day = 5'($urandom_range(1, len));
		end
		return dt;
	endfunction

	function automatic cda_pkg::req_t random_item();
		cda_pkg::req_t r;
		cal_date_t     a, b, t;
		int unsigned   roll;
		roll = $urandom_range(0, 99);
		// raw noise: every bit of every field, invalid dates included
		r.command  = 1'($urandom);
		r.day_a    = 5'($urandom);
		r.month_a  = 4'($urandom);
		r.year_a   = 7'($urandom);
		r.day_b    = 5'($urandom);
		r.month_b  = 4'($urandom);
		r.year_b   = 7'($urandom);
		r.add_days = 16'($urandom);
		if (roll < 14) begin
			return r;
		end
		a = random_date();
		b = random_date();
		if (roll < 58) begin
			// add with a spread of offsets, long ones run past the last year
			r.command = cda_pkg::CMD_ADD;
			roll = $urandom_range(0, 99);
			if (roll < 60) begin
				r.add_days = 16'($urandom_range(0, 1500));
			end else if (roll < 85) begin
				r.add_days = 16'($urandom_range(0, 20000));
			end
		end else begin
			r.command = cda_pkg::CMD_DIFF;
			roll = $urandom_range(0, 99);
			if (roll < 15) begin
				b = a;
			end else if (roll < 85 && day_ordinal(a.day, a.month, a.year)
					< day_ordinal(b.day, b.month, b.year)) begin
				// mostly in order, the rest gives order errors
				t = a;
				a = b;
				b = t;
			end
		end
		r.day_a   = a.day;
		r.month_a = a.month;
		r.year_a  = a.year;
		if (r.command == cda_pkg::CMD_DIFF) begin
			r.day_b   = b.day;
			r.month_b = b.month;
			r.year_b  = b.year;
		end
		return r;
	endfunction

	// offer one item and hold it while req_stall reads high
	task automatic send_item(input cda_pkg::req_t item);
		int unsigned gap;
		gap = sender_gaps_on ? pick_gap() : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
	endtask

	// stop offering and wait until every predicted result is back
	task automatic wait_results_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_dates.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic send_random_items(input int unsigned count);
		repeat (count) begin
			send_item(random_item());
		end
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// field extremes, both commands, leap rules and every error status
	task automatic test_directed_cases();
		sender_gaps_on   = 1'b0;
		receiver_gaps_on = 1'b0;
		// difference: zero, widest span, order error, leap and common february
		send_item(make_req(cda_pkg::CMD_DIFF,  1,  1,  0,  1,  1,  0, 0));
		send_item(make_req(cda_pkg::CMD_DIFF, 31, 12, 99,  1,  1,  0, 0));
		send_item(make_req(cda_pkg::CMD_DIFF,  1,  1,  0, 31, 12, 99, 0));
		send_item(make_req(cda_pkg::CMD_DIFF, 29,  2, 96, 28,  2, 96, 0));
		send_item(make_req(cda_pkg::CMD_DIFF,  1,  3, 97, 28,  2, 97, 0));
		// add_days is ignored by the difference
		send_item(make_req(cda_pkg::CMD_DIFF, 15,  6, 50, 14,  6, 50, 16'hffff));
		// add: zero offset, last day, overflow just past the span, largest offset
		send_item(make_req(cda_pkg::CMD_ADD, 15,  6, 50,  0,  0,  0, 0));
		send_item(make_req(cda_pkg::CMD_ADD, 31, 12, 99,  0,  0,  0, 0));
		send_item(make_req(cda_pkg::CMD_ADD, 31, 12, 99,  0,  0,  0, 1));
		send_item(make_req(cda_pkg::CMD_ADD,  1,  1,  0,  0,  0,  0, SPAN_DAYS - 1));
		send_item(make_req(cda_pkg::CMD_ADD,  1,  1,  0,  0,  0,  0, SPAN_DAYS));
		send_item(make_req(cda_pkg::CMD_ADD,  1,  1,  0,  0,  0,  0, 16'hffff));
		// add across leap and common february, and to the last day of a leap year
		send_item(make_req(cda_pkg::CMD_ADD, 28,  2,  0,  0,  0,  0, 1));
		send_item(make_req(cda_pkg::CMD_ADD, 28,  2,  1,  0,  0,  0, 1));
		send_item(make_req(cda_pkg::CMD_ADD,  1,  1,  0,  0,  0,  0, 365));
		// invalid dates: month zero and above twelve, day zero, short months, year
		send_item(make_req(cda_pkg::CMD_DIFF,  1,  0, 10,  1,  1, 10, 0));
		send_item(make_req(cda_pkg::CMD_ADD,   1, 13, 10,  1,  1, 10, 5));
		send_item(make_req(cda_pkg::CMD_DIFF,  1,  1, 10, 31, 15, 10, 0));
		send_item(make_req(cda_pkg::CMD_ADD,   0,  5, 10,  1,  1, 10, 5));
		send_item(make_req(cda_pkg::CMD_DIFF, 31,  4, 10,  1,  1, 10, 0));
		send_item(make_req(cda_pkg::CMD_ADD,  29,  2,  1,  1,  1,  0, 5));
		send_item(make_req(cda_pkg::CMD_DIFF,  1,  1, 50,  1,  1, 100, 0));
		send_item(make_req(cda_pkg::CMD_ADD,   1,  1, 127, 1,  1,  0, 5));
		// add with a garbage second date still succeeds
		send_item(make_req(cda_pkg::CMD_ADD,  31,  1, 42,  0, 15, 127, 30));
		wait_results_drained();
	endtask

	// random items at full rate on both sides
	task automatic test_full_rate_stream();
		sender_gaps_on   = 1'b0;
		receiver_gaps_on = 1'b0;
		send_random_items(250);
		wait_results_drained();
	endtask

	// random items with random idle cycles on both sides
	task automatic test_random_idle_stream();
		sender_gaps_on   = 1'b1;
		receiver_gaps_on = 1'b1;
		send_random_items(860);
		wait_results_drained();
	endtask

	// receiver holds off long enough for the block to stall its input
	task automatic test_result_backpressure();
		sender_gaps_on   = 1'b0;
		receiver_gaps_on = 1'b0;
		hold_off_cycles  = 60;
		send_random_items(16);
		wait_results_drained();
	endtask

	// ---------------------------------------------------------------
	// receiver: random stalls, plus a long hold when a test asks for it
	// ---------------------------------------------------------------
	initial begin : receiver
		int unsigned n;
		forever begin
			@(posedge clk);
			if (hold_off_cycles != 0) begin
				n = hold_off_cycles;
				hold_off_cycles = 0;
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (receiver_gaps_on) begin
				n = pick_gap();
				if (n != 0) begin
					rsp_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// checker: values sampled at the edge are the ones the block saw
	// ---------------------------------------------------------------
	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		cda_pkg::rsp_t want;
		if (arst_n) begin
			// results always leave at a later edge than the one their item is accepted at, so pop first
			if (rsp_valid && !rsp_stall) begin
				if (expected_dates.size() == 0) begin
					$error("result item with no pending request");
					mismatch_count++;
				end else begin
					want = expected_dates.pop_front();
					check_field("result_day",   16'(want.result_day),   16'(rsp.result_day));
					check_field("result_month", 16'(want.result_month), 16'(rsp.result_month));
					check_field("result_year",  16'(want.result_year),  16'(rsp.result_year));
					check_field("day_count",    want.day_count,         rsp.day_count);
					check_field("status",       16'(want.status),       16'(rsp.status));
				end
			end
			if (req_valid && !req_stall) begin
				expected_dates.push_back(calc_date_result(req));
			end
		end
	end

	// watchdog: a hang shows up as a long run of cycles with no handshake
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("calendar_date_arithmetic test failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_full_rate_stream();
		test_result_backpressure();
		test_random_idle_stream();
		// anything arriving now would be a spurious result
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_dates.size() == 0) begin
			$display("calendar_date_arithmetic test passed");
		end else begin
			$display("calendar_date_arithmetic test failed");
		end
		$finish;
	end

endmodule
